// ===== src/fdd_pkg.sv =====
// Shared types and default constants for the finite difference differentiator.
// No dependencies; imported by every module of the block.
package fdd_pkg;

    localparam int DATA_WIDTH_DEF  = 32;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int INDEX_WIDTH_DEF = 20;

    // Number of samples held in the sliding window.
    localparam int WIN_DEPTH = 5;

    // Per-row control passed from the front end to the back end.
    typedef struct packed {
        logic [1:0] ahead;  // samples that follow the row's sample in the window
        logic [1:0] prior;  // samples that precede it, capped at two
        logic       tiny;   // series shorter than three samples
        logic       last;   // last row of the series
    } t_row_ctl;

endpackage

// ===== src/fdd_queue.sv =====
// Two-entry task queue between the front end and the back end.
// Depends on fdd_pkg.
module fdd_queue import fdd_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    logic [WIDTH-1:0] r_mem [2];
    logic             r_wp;
    logic             r_rp;
    logic [1:0]       r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);

endmodule

// ===== src/fdd_front.sv =====
// Front end: takes samples, keeps the five-sample window and the sample count,
// and queues one task per row to emit. Depends on fdd_pkg.
module fdd_front import fdd_pkg::*; #(
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF,
    parameter int TASK_WIDTH  = 10 * DATA_WIDTH + INDEX_WIDTH + $bits(t_row_ctl)
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic signed [DATA_WIDTH-1:0] i_sample_time,
    input  logic signed [DATA_WIDTH-1:0] i_sample_position,
    input  logic                         i_final_sample,
    output logic                         o_push,
    output logic [TASK_WIDTH-1:0]        o_task,
    input  logic                         i_full
);

    logic signed [DATA_WIDTH-1:0] r_tw [WIN_DEPTH];
    logic signed [DATA_WIDTH-1:0] r_pw [WIN_DEPTH];
    logic [2:0]             r_fill;
    logic [INDEX_WIDTH-1:0] r_seen;
    logic [INDEX_WIDTH-1:0] r_base;
    logic [1:0]             r_pend;
    logic [1:0]             r_dist;
    logic                   r_fin;
    logic                   r_tiny;

    logic       accept;
    logic [2:0] n_fill;
    logic [2:0] prior_raw;
    t_row_ctl   ctl;

    assign o_ready = (r_pend == 2'd0);
    assign accept  = i_valid && o_ready;
    assign o_push  = (r_pend != 2'd0) && !i_full;
    assign n_fill  = (r_fill < 3'd5) ? r_fill + 3'd1 : 3'd5;

    assign prior_raw = r_fill - 3'd1 - {1'b0, r_dist};

    always_comb begin
        ctl.ahead = r_dist;
        ctl.prior = (prior_raw > 3'd2) ? 2'd2 : prior_raw[1:0];
        ctl.tiny  = r_tiny;
        ctl.last  = r_fin && (r_dist == 2'd0);
        o_task = '0;
        o_task[10*DATA_WIDTH +: INDEX_WIDTH] = r_base - INDEX_WIDTH'(r_dist);
        o_task[10*DATA_WIDTH + INDEX_WIDTH +: $bits(t_row_ctl)] = ctl;
        for (int j = 0; j < WIN_DEPTH; j++) begin
            o_task[j*DATA_WIDTH +: DATA_WIDTH] = r_pw[j];
            o_task[(WIN_DEPTH+j)*DATA_WIDTH +: DATA_WIDTH] = r_tw[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            for (int j = 0; j < WIN_DEPTH-1; j++) begin
                r_tw[j] <= r_tw[j+1];
                r_pw[j] <= r_pw[j+1];
            end
            r_tw[WIN_DEPTH-1] <= i_sample_time;
            r_pw[WIN_DEPTH-1] <= i_sample_position;
            r_base <= r_seen;
            r_fin  <= i_final_sample;
            r_tiny <= i_final_sample && (n_fill < 3'd3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= 3'd0;
            r_seen <= '0;
            r_pend <= 2'd0;
            r_dist <= 2'd0;
        end else if (accept) begin
            r_fill <= n_fill;
            if (i_final_sample) begin
                r_seen <= '0;
                r_pend <= (n_fill > 3'd3) ? 2'd3 : n_fill[1:0];
                r_dist <= (n_fill > 3'd3) ? 2'd2 : n_fill[1:0] - 2'd1;
            end else begin
                r_seen <= r_seen + INDEX_WIDTH'(1);
                r_pend <= (n_fill >= 3'd3) ? 2'd1 : 2'd0;
                r_dist <= 2'd2;
            end
        end else if (o_push) begin
            r_pend <= r_pend - 2'd1;
            r_dist <= r_dist - 2'd1;
            // flush done: the next series starts with an empty window
            if (r_pend == 2'd1 && r_fin) begin
                r_fill <= 3'd0;
            end
        end
    end

endmodule

// ===== src/fdd_div.sv =====
// Shared restoring divider: ((a-b) << FRAC_BITS) / (c-d), truncated toward
// zero and saturated; a zero divisor gives 0 with the fault flag. Depends on fdd_pkg.
module fdd_div import fdd_pkg::*; #(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic signed [DATA_WIDTH-1:0] i_a,
    input  logic signed [DATA_WIDTH-1:0] i_b,
    input  logic signed [DATA_WIDTH-1:0] i_c,
    input  logic signed [DATA_WIDTH-1:0] i_d,
    output logic                         o_done,
    output logic signed [DATA_WIDTH-1:0] o_quo,
    output logic                         o_fault
);

    localparam int MW = DATA_WIDTH + 1;
    localparam int QW = MW + FRAC_BITS;
    localparam int CW = $clog2(QW + 1);
    localparam logic [QW-1:0] LIM = QW'(1) << (DATA_WIDTH - 1);

    logic [MW-1:0] num_diff, den_diff, num_mag, den_mag;
    logic          num_neg, den_neg;
    logic [MW:0]   rem_sh, rem_sub;
    logic          ge;

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [QW-1:0] r_num;
    logic [QW-1:0] r_quo;
    logic [MW-1:0] r_rem;
    logic [MW-1:0] r_den;
    logic          r_neg;
    logic          r_fault;
    logic signed [DATA_WIDTH-1:0] r_res;

    assign num_diff = {i_a[DATA_WIDTH-1], i_a} - {i_b[DATA_WIDTH-1], i_b};
    assign den_diff = {i_c[DATA_WIDTH-1], i_c} - {i_d[DATA_WIDTH-1], i_d};
    assign num_neg  = num_diff[MW-1];
    assign den_neg  = den_diff[MW-1];
    assign num_mag  = num_neg ? ~num_diff + MW'(1) : num_diff;
    assign den_mag  = den_neg ? ~den_diff + MW'(1) : den_diff;

    assign rem_sh  = {r_rem, r_num[QW-1]};
    assign ge      = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= QW'(num_mag) << FRAC_BITS;
            r_rem <= '0;
            r_quo <= '0;
            r_den <= den_mag;
            r_neg <= num_neg ^ den_neg;
            r_fault <= (den_mag == '0);
            r_res <= '0;
        end else if (r_busy && r_cnt != '0) begin
            r_num <= r_num << 1;
            r_rem <= ge ? rem_sub[MW-1:0] : rem_sh[MW-1:0];
            r_quo <= {r_quo[QW-2:0], ge};
        end else if (r_busy) begin
            if (r_neg) begin
                r_res <= (r_quo > LIM) ? {1'b1, {(DATA_WIDTH-1){1'b0}}}
                                       : ~r_quo[DATA_WIDTH-1:0] + DATA_WIDTH'(1);
            end else begin
                r_res <= (r_quo >= LIM) ? {1'b0, {(DATA_WIDTH-1){1'b1}}}
                                        : r_quo[DATA_WIDTH-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                if (den_mag == '0) begin
                    r_done <= 1'b1;
                end else begin
                    r_busy <= 1'b1;
                    r_cnt  <= CW'(QW);
                end
            end else if (r_busy) begin
                if (r_cnt != '0) begin
                    r_cnt <= r_cnt - CW'(1);
                end else begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done  = r_done;
    assign o_quo   = r_res;
    assign o_fault = r_fault;

endmodule

// ===== src/fdd_back.sv =====
// Back end: takes one row task, steps through its divisions on the shared
// divider and holds the finished row in the output register. Depends on fdd_pkg, fdd_div.
module fdd_back import fdd_pkg::*; #(
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF,
    parameter int TASK_WIDTH  = 10 * DATA_WIDTH + INDEX_WIDTH + $bits(t_row_ctl)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [TASK_WIDTH-1:0]         i_task,
    input  logic                          i_empty,
    output logic                          o_pop,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [INDEX_WIDTH-1:0]        o_row_index,
    output logic signed [DATA_WIDTH-1:0]  o_row_time,
    output logic signed [DATA_WIDTH-1:0]  o_row_position,
    output logic signed [DATA_WIDTH-1:0]  o_vel_forward,
    output logic signed [DATA_WIDTH-1:0]  o_vel_backward,
    output logic signed [DATA_WIDTH-1:0]  o_vel_central,
    output logic signed [DATA_WIDTH-1:0]  o_acc_forward,
    output logic signed [DATA_WIDTH-1:0]  o_acc_backward,
    output logic signed [DATA_WIDTH-1:0]  o_acc_central,
    output logic                          o_divide_fault,
    output logic                          o_end_of_run
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_OUT  = 2'd3;

    localparam logic [3:0] SP_VF   = 4'd0;
    localparam logic [3:0] SP_VB   = 4'd1;
    localparam logic [3:0] SP_VC   = 4'd2;
    localparam logic [3:0] SP_VF1  = 4'd3;
    localparam logic [3:0] SP_AF   = 4'd4;
    localparam logic [3:0] SP_VB0  = 4'd5;
    localparam logic [3:0] SP_AB   = 4'd6;
    localparam logic [3:0] SP_VCP  = 4'd7;
    localparam logic [3:0] SP_VCM  = 4'd8;
    localparam logic [3:0] SP_AC   = 4'd9;
    localparam logic [3:0] SP_DONE = 4'd10;

    logic [1:0] r_state;
    logic [3:0] r_step;
    t_row_ctl   r_ctl;
    logic [INDEX_WIDTH-1:0]       r_idx;
    logic signed [DATA_WIDTH-1:0] r_tw [WIN_DEPTH];
    logic signed [DATA_WIDTH-1:0] r_pw [WIN_DEPTH];
    logic signed [DATA_WIDTH-1:0] r_vf, r_vb, r_vc, r_af, r_ab, r_ac, r_ta, r_tb;
    logic                         r_fault;

    logic [2:0] c0, cm1, cm2, cp1, cp2;
    logic       a1, a2, b1, b2, step_en, div_start, div_done, div_fault;
    logic signed [DATA_WIDTH-1:0] op_a, op_b, op_c, op_d, div_quo;

    // window slots around the row's sample, clamped to the window
    assign c0  = 3'd4 - {1'b0, r_ctl.ahead};
    assign cm1 = (c0 == 3'd0) ? 3'd0 : c0 - 3'd1;
    assign cm2 = (c0 < 3'd2) ? 3'd0 : c0 - 3'd2;
    assign cp1 = (c0 == 3'd4) ? 3'd4 : c0 + 3'd1;
    assign cp2 = (c0 >= 3'd3) ? 3'd4 : c0 + 3'd2;

    assign a1 = !r_ctl.tiny && (r_ctl.ahead != 2'd0);
    assign a2 = !r_ctl.tiny && (r_ctl.ahead == 2'd2);
    assign b1 = !r_ctl.tiny && (r_ctl.prior != 2'd0);
    assign b2 = !r_ctl.tiny && (r_ctl.prior == 2'd2);

    always_comb begin
        step_en = 1'b0;
        op_a = r_pw[cp1];
        op_b = r_pw[c0];
        op_c = r_tw[cp1];
        op_d = r_tw[c0];
        unique case (r_step)
            SP_VF: begin
                step_en = a1;
            end
            SP_VB: begin
                step_en = b1;
                op_a = r_pw[c0];  op_b = r_pw[cm1];
                op_c = r_tw[c0];  op_d = r_tw[cm1];
            end
            SP_VC: begin
                step_en = a1 && b1;
                op_a = r_pw[cp1]; op_b = r_pw[cm1];
                op_c = r_tw[cp1]; op_d = r_tw[cm1];
            end
            SP_VF1: begin
                step_en = a2;
                op_a = r_pw[cp2]; op_b = r_pw[cp1];
                op_c = r_tw[cp2]; op_d = r_tw[cp1];
            end
            SP_AF: begin
                step_en = a2;
                op_a = r_ta;      op_b = r_vf;
            end
            SP_VB0: begin
                step_en = b2;
                op_a = r_pw[cm1]; op_b = r_pw[cm2];
                op_c = r_tw[cm1]; op_d = r_tw[cm2];
            end
            SP_AB: begin
                step_en = b2;
                op_a = r_vb;      op_b = r_ta;
                op_c = r_tw[c0];  op_d = r_tw[cm1];
            end
            SP_VCP: begin
                step_en = a2 && b2;
                op_a = r_pw[cp2]; op_b = r_pw[c0];
                op_c = r_tw[cp2]; op_d = r_tw[c0];
            end
            SP_VCM: begin
                step_en = a2 && b2;
                op_a = r_pw[c0];  op_b = r_pw[cm2];
                op_c = r_tw[c0];  op_d = r_tw[cm2];
            end
            SP_AC: begin
                step_en = a2 && b2;
                op_a = r_ta;      op_b = r_tb;
                op_c = r_tw[cp1]; op_d = r_tw[cm1];
            end
            default: begin
                step_en = 1'b0;
            end
        endcase
    end

    assign o_pop     = (r_state == ST_IDLE) && !i_empty;
    assign div_start = (r_state == ST_RUN) && (r_step != SP_DONE) && step_en;

    fdd_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_a     (op_a),
        .i_b     (op_b),
        .i_c     (op_c),
        .i_d     (op_d),
        .o_done  (div_done),
        .o_quo   (div_quo),
        .o_fault (div_fault)
    );

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            for (int j = 0; j < WIN_DEPTH; j++) begin
                r_pw[j] <= i_task[j*DATA_WIDTH +: DATA_WIDTH];
                r_tw[j] <= i_task[(WIN_DEPTH+j)*DATA_WIDTH +: DATA_WIDTH];
            end
            r_idx <= i_task[10*DATA_WIDTH +: INDEX_WIDTH];
            r_ctl <= i_task[10*DATA_WIDTH + INDEX_WIDTH +: $bits(t_row_ctl)];
            r_vf <= '0; r_vb <= '0; r_vc <= '0;
            r_af <= '0; r_ab <= '0; r_ac <= '0;
            r_ta <= '0; r_tb <= '0;
            r_fault <= 1'b0;
        end else if (r_state == ST_WAIT && div_done) begin
            r_fault <= r_fault | div_fault;
            case (r_step)
                SP_VF:  r_vf <= div_quo;
                SP_VB:  r_vb <= div_quo;
                SP_VC:  r_vc <= div_quo;
                SP_AF:  r_af <= div_quo;
                SP_AB:  r_ab <= div_quo;
                SP_VCM: r_tb <= div_quo;
                SP_AC:  r_ac <= div_quo;
                default: r_ta <= div_quo;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= SP_VF;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop) begin
                        r_state <= ST_RUN;
                        r_step  <= SP_VF;
                    end
                end
                ST_RUN: begin
                    if (r_step == SP_DONE) begin
                        r_state <= ST_OUT;
                    end else if (step_en) begin
                        r_state <= ST_WAIT;
                    end else begin
                        r_step <= r_step + 4'd1;
                    end
                end
                ST_WAIT: begin
                    if (div_done) begin
                        r_step  <= r_step + 4'd1;
                        r_state <= ST_RUN;
                    end
                end
                ST_OUT: begin
                    if (i_ready) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_valid        = (r_state == ST_OUT);
    assign o_row_index    = r_idx;
    assign o_row_time     = r_tw[c0];
    assign o_row_position = r_pw[c0];
    assign o_vel_forward  = r_vf;
    assign o_vel_backward = r_vb;
    assign o_vel_central  = r_vc;
    assign o_acc_forward  = r_af;
    assign o_acc_backward = r_ab;
    assign o_acc_central  = r_ac;
    assign o_divide_fault = r_fault;
    assign o_end_of_run   = r_ctl.last;

endmodule

// ===== src/finite_difference_differentiator.sv =====
// Finite difference differentiator: a stream of (time, position) samples in
// signed fixed point goes in, and for each sample index one row comes out two
// samples late with forward, backward and central velocities and accelerations;
// a sample flagged final flushes the last rows (up to three) and starts a new
// series. Each row runs through up to ten divisions on one shared restoring
// divider, one at a time, in Q16.16 at the default widths; a division by a zero
// time step ends early with the fault flag. A row near a series boundary needs
// fewer divisions, and the back end pops the next row only once the last one
// is taken; the divider sets the rate. A two-entry task queue lets the
// front end take samples while the back end is busy or a row waits to be taken.
// Depends on fdd_pkg, fdd_front, fdd_queue, fdd_back.
module finite_difference_differentiator import fdd_pkg::*; #(
    parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int INDEX_WIDTH = INDEX_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [DATA_WIDTH-1:0]  i_sample_time,
    input  logic signed [DATA_WIDTH-1:0]  i_sample_position,
    input  logic                          i_final_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [INDEX_WIDTH-1:0]        o_row_index,
    output logic signed [DATA_WIDTH-1:0]  o_row_time,
    output logic signed [DATA_WIDTH-1:0]  o_row_position,
    output logic signed [DATA_WIDTH-1:0]  o_vel_forward,
    output logic signed [DATA_WIDTH-1:0]  o_vel_backward,
    output logic signed [DATA_WIDTH-1:0]  o_vel_central,
    output logic signed [DATA_WIDTH-1:0]  o_acc_forward,
    output logic signed [DATA_WIDTH-1:0]  o_acc_backward,
    output logic signed [DATA_WIDTH-1:0]  o_acc_central,
    output logic                          o_divide_fault,
    output logic                          o_end_of_run
);

    localparam int TASK_WIDTH = 10 * DATA_WIDTH + INDEX_WIDTH + $bits(t_row_ctl);

    logic                  q_push, q_pop, q_full, q_empty;
    logic [TASK_WIDTH-1:0] q_in, q_out;

    fdd_front #(
        .DATA_WIDTH  (DATA_WIDTH),
        .INDEX_WIDTH (INDEX_WIDTH),
        .TASK_WIDTH  (TASK_WIDTH)
    ) u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_sample_time     (i_sample_time),
        .i_sample_position (i_sample_position),
        .i_final_sample    (i_final_sample),
        .o_push            (q_push),
        .o_task            (q_in),
        .i_full            (q_full)
    );

    fdd_queue #(
        .WIDTH (TASK_WIDTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    fdd_back #(
        .DATA_WIDTH  (DATA_WIDTH),
        .FRAC_BITS   (FRAC_BITS),
        .INDEX_WIDTH (INDEX_WIDTH),
        .TASK_WIDTH  (TASK_WIDTH)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_task         (q_out),
        .i_empty        (q_empty),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_row_index    (o_row_index),
        .o_row_time     (o_row_time),
        .o_row_position (o_row_position),
        .o_vel_forward  (o_vel_forward),
        .o_vel_backward (o_vel_backward),
        .o_vel_central  (o_vel_central),
        .o_acc_forward  (o_acc_forward),
        .o_acc_backward (o_acc_backward),
        .o_acc_central  (o_acc_central),
        .o_divide_fault (o_divide_fault),
        .o_end_of_run   (o_end_of_run)
    );

    // queue never takes a transfer while full, never pops while empty
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_full)
        else $error("task queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("task queue underflow");

    // a final sample always leaves at least one row to flush
    a_flush_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_final_sample |=> !o_ready)
        else $error("final sample did not start a flush");

    // the last row has no following sample, so forward terms are zero
    a_last_row_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_end_of_run |-> o_vel_forward == '0 && o_acc_forward == '0)
        else $error("forward term on last row");

endmodule

// ===== dv/tb_finite_difference_differentiator.sv =====
// Self-checking bench for finite_difference_differentiator: random and directed
// sample series, with a built-in row predictor and an in-order row check.
// Depends on fdd_pkg and the block's RTL.
`timescale 1ns / 100ps

module tb_finite_difference_differentiator import fdd_pkg::*;;

    localparam int DW = DATA_WIDTH_DEF;
    localparam int FB = FRAC_BITS_DEF;
    localparam int IW = INDEX_WIDTH_DEF;
    localparam int HOLD_LEN = 4000;

    typedef struct packed {
        logic [IW-1:0]        index;
        logic signed [DW-1:0] t;
        logic signed [DW-1:0] p;
        logic signed [DW-1:0] vf;
        logic signed [DW-1:0] vb;
        logic signed [DW-1:0] vc;
        logic signed [DW-1:0] af;
        logic signed [DW-1:0] ab;
        logic signed [DW-1:0] ac;
        logic                 fault;
        logic                 eor;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    logic signed [DW-1:0] i_sample_time = '0;
    logic signed [DW-1:0] i_sample_position = '0;
    logic                 i_final_sample = 1'b0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    t_row                 act;

    finite_difference_differentiator u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_sample_time(i_sample_time), .i_sample_position(i_sample_position),
        .i_final_sample(i_final_sample),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_row_index(act.index), .o_row_time(act.t), .o_row_position(act.p),
        .o_vel_forward(act.vf), .o_vel_backward(act.vb), .o_vel_central(act.vc),
        .o_acc_forward(act.af), .o_acc_backward(act.ab), .o_acc_central(act.ac),
        .o_divide_fault(act.fault), .o_end_of_run(act.eor)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // predictor state
    longint     time_win [WIN_DEPTH];
    longint     pos_win [WIN_DEPTH];
    logic [IW-1:0] next_index;
    int         fill;
    bit         row_fault;
    t_row       expected_rows[$];

    int  mismatches = 0;
    bit  calm;            // no idling on either side
    int  hold_reqs = 0;   // receiver hold-offs asked for by the tests
    int  hold_seen = 0;   // hold-offs the receiver has started
    int  hold_cycles = 0; // receiver hold-off, counted down below
    longint cur_t;

    // (a-b)/(c-d) in fixed point, truncated toward zero, saturated
    function automatic longint quot(longint a, longint b, longint c, longint d);
        longint nm, dm, q;
        bit neg;
        nm = a - b;
        dm = c - d;
        if (dm == 0) begin
            row_fault = 1'b1;
            return 0;
        end
        neg = (nm < 0) != (dm < 0);
        if (nm < 0) nm = -nm;
        if (dm < 0) dm = -dm;
        q = (nm <<< FB) / dm;
        if (neg) return (q > 64'sd2147483648) ? -64'sd2147483648 : -q;
        return (q > 64'sd2147483647) ? 64'sd2147483647 : q;
    endfunction

    function automatic int clampw(int j);
        return j < 0 ? 0 : (j > 4 ? 4 : j);
    endfunction

    function automatic t_row build_row(int d, bit fin, bit tiny);
        t_row r;
        int c, prior, after;
        longint vf, vb, vc, af, ab, ac, v1, v2;
        c = 4 - d;
        prior = fill - 1 - d;
        if (prior > 2) prior = 2;
        after = d;
        vf = 0; vb = 0; vc = 0; af = 0; ab = 0; ac = 0;
        row_fault = 1'b0;
        if (!tiny) begin
            if (after >= 1)
                vf = quot(pos_win[clampw(c+1)], pos_win[c], time_win[clampw(c+1)], time_win[c]);
            if (prior >= 1)
                vb = quot(pos_win[c], pos_win[clampw(c-1)], time_win[c], time_win[clampw(c-1)]);
            if (prior >= 1 && after >= 1)
                vc = quot(pos_win[clampw(c+1)], pos_win[clampw(c-1)],
                          time_win[clampw(c+1)], time_win[clampw(c-1)]);
            if (after >= 2) begin
                v1 = quot(pos_win[clampw(c+2)], pos_win[clampw(c+1)],
                          time_win[clampw(c+2)], time_win[clampw(c+1)]);
                af = quot(v1, vf, time_win[clampw(c+1)], time_win[c]);
            end
            if (prior >= 2) begin
                v1 = quot(pos_win[clampw(c-1)], pos_win[clampw(c-2)],
                          time_win[clampw(c-1)], time_win[clampw(c-2)]);
                ab = quot(vb, v1, time_win[c], time_win[clampw(c-1)]);
            end
            if (prior >= 2 && after >= 2) begin
                v1 = quot(pos_win[clampw(c+2)], pos_win[c], time_win[clampw(c+2)], time_win[c]);
                v2 = quot(pos_win[c], pos_win[clampw(c-2)], time_win[c], time_win[clampw(c-2)]);
                ac = quot(v1, v2, time_win[clampw(c+1)], time_win[clampw(c-1)]);
            end
        end
        r.index = next_index - IW'(d);
        r.t = DW'(time_win[c]);
        r.p = DW'(pos_win[c]);
        r.vf = DW'(vf); r.vb = DW'(vb); r.vc = DW'(vc);
        r.af = DW'(af); r.ab = DW'(ab); r.ac = DW'(ac);
        r.fault = row_fault;
        r.eor = fin && d == 0;
        return r;
    endfunction

    function automatic void clear_series();
        for (int j = 0; j < WIN_DEPTH; j++) begin
            time_win[j] = 0;
            pos_win[j] = 0;
        end
        next_index = '0;
        fill = 0;
    endfunction

    function automatic void queue_row(t_row r);
        expected_rows.insert(expected_rows.size(), r);
    endfunction

    function automatic void predict_rows(logic signed [DW-1:0] t, logic signed [DW-1:0] p,
                                         bit fin);
        int d;
        for (int j = 0; j < 4; j++) begin
            time_win[j] = time_win[j+1];
            pos_win[j] = pos_win[j+1];
        end
        time_win[4] = longint'(t);
        pos_win[4] = longint'(p);
        if (fill < 5) fill++;
        if (fin) begin
            d = fill - 1;
            if (d > 2) d = 2;
            for (; d >= 0; d--)
                queue_row(build_row(d, 1'b1, fill < 3));
            clear_series();
        end else begin
            if (fill >= 3) queue_row(build_row(2, 1'b0, 1'b0));
            next_index++;
        end
    endfunction

    task automatic send_sample(logic signed [DW-1:0] t, logic signed [DW-1:0] p, bit fin);
        if (!calm && $urandom_range(99) < 25) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_sample_time <= t;
        i_sample_position <= p;
        i_final_sample <= fin;
        @(negedge i_clk);
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);   // transfer happens on this edge
        predict_rows(t, p, fin);
    endtask

    task automatic idle_input();
        i_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // receiver
    always @(posedge i_clk) begin
        if (hold_reqs != hold_seen) begin
            hold_seen <= hold_reqs;
            hold_cycles <= HOLD_LEN;
            i_ready <= 1'b0;
        end else if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= calm || ($urandom_range(99) >= 25);
        end
    end

    // row check
    always @(posedge i_clk) begin
        t_row e;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_rows.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected row: %h", act);
            end else begin
                e = expected_rows.pop_front();
                if (act.index !== e.index || act.t !== e.t || act.p !== e.p ||
                    act.vf !== e.vf || act.vb !== e.vb || act.vc !== e.vc ||
                    act.af !== e.af || act.ab !== e.ab || act.ac !== e.ac ||
                    act.fault !== e.fault || act.eor !== e.eor) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("row %0d mismatch", e.index);
                        $display("  exp idx=%h t=%h p=%h v=%h %h %h a=%h %h %h f=%b e=%b",
                                 e.index, e.t, e.p, e.vf, e.vb, e.vc, e.af, e.ab, e.ac,
                                 e.fault, e.eor);
                        $display("  act idx=%h t=%h p=%h v=%h %h %h a=%h %h %h f=%b e=%b",
                                 act.index, act.t, act.p, act.vf, act.vb, act.vc, act.af,
                                 act.ab, act.ac, act.fault, act.eor);
                    end
                end
            end
        end
    end

    function automatic logic [DW-1:0] rand_word();
        return {$urandom()};
    endfunction

    // time that mostly advances, with repeats and wild jumps now and then
    function automatic logic signed [DW-1:0] next_time();
        int r;
        r = $urandom_range(99);
        if (r < 8) return DW'(cur_t);
        if (r < 16) cur_t = longint'($signed(rand_word()));
        else cur_t = cur_t + $urandom_range(1, 32'h0003_0000);
        return DW'(cur_t);
    endfunction

    function automatic logic signed [DW-1:0] rand_pos();
        if ($urandom_range(3) == 0) return rand_word();
        return $signed(DW'($urandom_range(0, 32'h0020_0000))) - 32'sh0010_0000;
    endfunction

    task automatic test_short_series();
        send_sample(32'sh0001_0000, 32'sh0002_0000, 1'b1);
        send_sample(32'sh0001_0000, 32'sh0002_0000, 1'b0);
        send_sample(32'sh0002_0000, 32'sh0005_0000, 1'b1);
        send_sample(32'sh0000_0000, 32'sh0000_0000, 1'b0);
        send_sample(32'sh0001_0000, 32'sh0001_0000, 1'b0);
        send_sample(32'sh0003_0000, 32'sh0009_0000, 1'b1);
        send_sample(32'sh0000_0000, 32'sh0000_0000, 1'b0);
        send_sample(32'sh0000_8000, 32'sh0001_0000, 1'b0);
        send_sample(32'sh0001_0000, 32'sh0004_0000, 1'b0);
        send_sample(32'sh0001_8000, 32'sh0009_0000, 1'b1);
    endtask

    // saturation both ways, zero time steps, the extremes of the fields
    task automatic test_extremes();
        send_sample(32'sh8000_0000, 32'sh8000_0000, 1'b0);
        send_sample(32'sh8000_0001, 32'sh7fff_ffff, 1'b0);
        send_sample(32'sh8000_0002, 32'sh8000_0000, 1'b0);
        send_sample(32'sh8000_0002, 32'sh0000_0000, 1'b0);
        send_sample(32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0);
        send_sample(32'sh7fff_ffff, 32'shffff_ffff, 1'b0);
        send_sample(32'sh0000_0000, 32'sh8000_0000, 1'b0);
        send_sample(32'shffff_ffff, 32'sh5555_5555, 1'b0);
        send_sample(32'sh0000_0001, 32'shaaaa_aaaa, 1'b1);
    endtask

    // receiver stalls for a long stretch while samples keep coming
    task automatic test_back_pressure();
        hold_reqs++;
        cur_t = 0;
        for (int n = 0; n < 14; n++)
            send_sample(next_time(), rand_pos(), n == 13);
    endtask

    task automatic test_random_series(int total);
        int sent, len;
        sent = 0;
        while (sent < total) begin
            calm = sent < 80;
            len = ($urandom_range(9) == 0) ? $urandom_range(1, 3) : $urandom_range(3, 30);
            cur_t = longint'($signed(DW'($urandom_range(0, 32'h00ff_ffff)))) - 32'sh0080_0000;
            for (int n = 0; n < len; n++)
                send_sample(next_time(), rand_pos(), n == len - 1);
            sent += len;
        end
        calm = 1'b0;
    endtask

    initial begin
        calm = 1'b0;
        cur_t = 0;
        clear_series();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_short_series();
        test_extremes();
        test_back_pressure();
        test_random_series(390);
        idle_input();
        while (expected_rows.size() != 0) @(posedge i_clk);
        repeat (1000) @(posedge i_clk);
        if (mismatches == 0 && expected_rows.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #40_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
src/fdd_pkg.sv
src/fdd_queue.sv
src/fdd_front.sv
src/fdd_div.sv
src/fdd_back.sv
src/finite_difference_differentiator.sv
dv/tb_finite_difference_differentiator.sv
